// ----- hw/rtl/rvl_pkg.sv -----
// ---------------------------------------------------------------------------
// RVL depth decoder package
// Shared widths, reset values and the result record.
// ---------------------------------------------------------------------------
`default_nettype none

package rvl_pkg;

   localparam int unsigned COUNT_BITS_DEF = 24;   // pixel counter width
   localparam int unsigned WORD_W         = 32;   // compressed word
   localparam int unsigned PIX_W          = 16;   // depth pixel
   localparam int unsigned REP_W          = 24;   // repeat count port
   localparam int unsigned CFG_W          = 24;   // pixels_per_image register
   localparam int unsigned NIBBLES        = 8;    // nibbles per word
   localparam int unsigned IN_DEPTH       = 2;    // word queue entries
   localparam int unsigned OUT_DEPTH      = 4;    // result queue entries

   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(307200);

   typedef struct packed {
      logic [PIX_W-1:0] pixel_value;
      logic [REP_W-1:0] repeat_count;
      logic             image_done;
      logic             run_overflow;
      logic             last;
   } result_type;

endpackage

`default_nettype wire

// ----- hw/rtl/rvl_depth_decoder.sv -----
// ---------------------------------------------------------------------------
// RVL depth decoder
// Decompresses an RVL depth image stream, one 32-bit word per request,
// into zero-run and pixel results.
// ---------------------------------------------------------------------------
//
//   channel   direction  handshake                 payload
//   req_      in         req_push / req_full       req_code_word[31:0]
//   rsp_      out        rsp_pop / rsp_empty       pixel_value, repeat_count,
//                                                  image_done, run_overflow, last
//   csr_      in         csr_wr_en (no wait)       csr_wr_data[23:0] pixels/image
//
// Flow: the nibble unit consumes one nibble per clock while the result queue
//   has room, walking every nibble of a request (fewer when the image ends
//   inside it); the next word is loaded in the cycle the current one finishes.
// Results: each result is held in the nibble unit until the next result or
//   the end of its word settles its last flag.
// Reset: synchronous; all control state clears at once, no clearing pass.
// Stalls: a 2-entry word queue decouples req_ from the nibble unit, and a
//   4-entry result queue decouples it from rsp_; the unit halts only when the
//   result queue is full.
// ---------------------------------------------------------------------------
`default_nettype none

module rvl_depth_decoder #(
   parameter int unsigned COUNT_BITS = rvl_pkg::COUNT_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request side
   input  wire logic                         req_push,
   output logic                              req_full,
   input  wire logic [rvl_pkg::WORD_W-1:0]   req_code_word,
   // result side
   output logic                              rsp_empty,
   input  wire logic                         rsp_pop,
   output logic      [rvl_pkg::PIX_W-1:0]    rsp_pixel_value,
   output logic      [rvl_pkg::REP_W-1:0]    rsp_repeat_count,
   output logic                              rsp_image_done,
   output logic                              rsp_run_overflow,
   output logic                              rsp_last,
   // configuration
   input  wire logic                         csr_wr_en,
   input  wire logic [rvl_pkg::CFG_W-1:0]    csr_wr_data
);

   localparam int unsigned RES_W = $bits(rvl_pkg::result_type);

   logic [rvl_pkg::CFG_W-1:0]  pixels_per_image_ff, pixels_per_image_in;

   logic                       word_empty, word_pop;
   logic [rvl_pkg::WORD_W-1:0] word_data;

   logic                       res_full, res_push;
   rvl_pkg::result_type        res_wr, res_rd;
   logic [RES_W-1:0]           res_rd_bits;

   // image size register, sampled by the unit at each image start
   assign pixels_per_image_in = csr_wr_en ? csr_wr_data : pixels_per_image_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixels_per_image_ff <= rvl_pkg::CFG_RESET;
      end else begin
         pixels_per_image_ff <= pixels_per_image_in;
      end
   end

   // front: compressed word queue
   rvl_fifo #(
      .WIDTH (rvl_pkg::WORD_W),
      .DEPTH (rvl_pkg::IN_DEPTH)
   ) u_word_q (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_data (req_code_word),
      .full    (req_full),
      .pop     (word_pop),
      .rd_data (word_data),
      .empty   (word_empty)
   );

   // back: nibble decoder
   rvl_nibble_unit #(
      .COUNT_BITS (COUNT_BITS)
   ) u_nibble (
      .clock      (clock),
      .reset      (reset),
      .word_valid (!word_empty),
      .word_data  (word_data),
      .word_pop   (word_pop),
      .cfg_pixels (pixels_per_image_ff),
      .out_full   (res_full),
      .out_push   (res_push),
      .out_data   (res_wr)
   );

   // result queue toward the consumer
   rvl_fifo #(
      .WIDTH (RES_W),
      .DEPTH (rvl_pkg::OUT_DEPTH)
   ) u_res_q (
      .clock   (clock),
      .reset   (reset),
      .push    (res_push),
      .wr_data (res_wr),
      .full    (res_full),
      .pop     (rsp_pop),
      .rd_data (res_rd_bits),
      .empty   (rsp_empty)
   );

   assign res_rd           = rvl_pkg::result_type'(res_rd_bits);
   assign rsp_pixel_value  = res_rd.pixel_value;
   assign rsp_repeat_count = res_rd.repeat_count;
   assign rsp_image_done   = res_rd.image_done;
   assign rsp_run_overflow = res_rd.run_overflow;
   assign rsp_last         = res_rd.last;

endmodule

`default_nettype wire

// ----- hw/rtl/rvl_fifo.sv -----
// ---------------------------------------------------------------------------
// RVL small queue
// Register-based FIFO, power-of-two depth, show-ahead read.
// ---------------------------------------------------------------------------
`default_nettype none

module rvl_fifo #(
   parameter int unsigned WIDTH = rvl_pkg::WORD_W,
   parameter int unsigned DEPTH = rvl_pkg::IN_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] rd_data,
   output logic                  empty
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      full    = (count_ff == (AW+1)'(DEPTH));
      empty   = (count_ff == '0);
      do_push = push && !full;
      do_pop  = pop && !empty;
      rd_data = mem_ff[rd_ptr_ff];

      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/rvl_nibble_unit.sv -----
// ---------------------------------------------------------------------------
// RVL nibble unit
// Walks one nibble per cycle unless out_full, builds values, runs the
// run-length / delta state machine and hands results to the result queue.
// ---------------------------------------------------------------------------
`default_nettype none

module rvl_nibble_unit #(
   parameter int unsigned COUNT_BITS = rvl_pkg::COUNT_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        word_valid,
   input  wire logic [rvl_pkg::WORD_W-1:0]  word_data,
   output logic                             word_pop,
   input  wire logic [rvl_pkg::CFG_W-1:0]   cfg_pixels,
   input  wire logic                        out_full,
   output logic                             out_push,
   output rvl_pkg::result_type              out_data
);

   localparam logic [1:0] PH_ZERO    = 2'd0;
   localparam logic [1:0] PH_NONZERO = 2'd1;
   localparam logic [1:0] PH_DELTA   = 2'd2;

   localparam logic [3:0] GRP_LIMIT = 4'd11;   // groups that still fit 32 bits
   localparam logic [3:0] GRP_SAT   = 4'hF;
   localparam logic [2:0] IDX_FIRST = 3'(rvl_pkg::NIBBLES - 1);

   logic                        busy_ff, busy_in;
   logic [rvl_pkg::WORD_W-1:0]  word_ff, word_in;
   logic [2:0]                  idx_ff, idx_in;
   logic [1:0]                  phase_ff, phase_in;
   logic [31:0]                 acc_ff, acc_in;
   logic [3:0]                  grp_ff, grp_in;
   logic [COUNT_BITS-1:0]       pix_ff, pix_in;
   logic [COUNT_BITS-1:0]       nz_ff, nz_in;
   logic [rvl_pkg::PIX_W-1:0]   prev_ff, prev_in;
   logic                        clip_ff, clip_in;
   logic                        pend_valid_ff, pend_valid_in;
   logic                        pend_fin_ff, pend_fin_in;
   rvl_pkg::result_type         pend_ff, pend_in;

   // effective state after the image-start override
   logic [1:0]                  phase_e;
   logic [31:0]                 acc_e;
   logic [3:0]                  grp_e;
   logic [COUNT_BITS-1:0]       pix_e, nz_e;
   logic [rvl_pkg::PIX_W-1:0]   prev_e;
   logic                        clip_e;

   logic                        step, start, ended, emit, word_end, load;
   logic [31:0]                 cfg_ext;
   logic [COUNT_BITS-1:0]       pix_load;
   logic [3:0]                  nib;
   logic [4:0]                  shamt;
   logic [31:0]                 acc_n;
   logic [3:0]                  grp_n;
   logic                        v_gt;
   logic [COUNT_BITS-1:0]       cnt, pix_dec, nz_dec, pix_sub;
   logic [31:0]                 cnt_ext;
   logic [rvl_pkg::PIX_W-1:0]   delta, cur;
   rvl_pkg::result_type         new_res;

   always_comb begin
      step     = busy_ff && !out_full;
      start    = (idx_ff == IDX_FIRST) && (phase_ff != PH_NONZERO) &&
                 (phase_ff != PH_DELTA) && (pix_ff == '0);
      cfg_ext  = {{(32 - rvl_pkg::CFG_W){1'b0}}, cfg_pixels};
      pix_load = cfg_ext[COUNT_BITS-1:0];

      if (start) begin
         phase_e = PH_ZERO;
         acc_e   = '0;
         grp_e   = '0;
         pix_e   = pix_load;
         nz_e    = '0;
         prev_e  = '0;
         clip_e  = 1'b0;
      end else begin
         phase_e = phase_ff;
         acc_e   = acc_ff;
         grp_e   = grp_ff;
         pix_e   = pix_ff;
         nz_e    = nz_ff;
         prev_e  = prev_ff;
         clip_e  = clip_ff;
      end

      // value assembly, three bits per nibble, low group first
      nib   = word_ff[{idx_ff, 2'b00} +: 4];
      shamt = {1'b0, grp_e} + {grp_e, 1'b0};
      acc_n = (grp_e < GRP_LIMIT) ? (acc_e | (32'(nib[2:0]) << shamt)) : acc_e;
      grp_n = (grp_e != GRP_SAT) ? grp_e + 1'b1 : grp_e;

      v_gt    = acc_n > 32'(pix_e);
      cnt     = v_gt ? pix_e : acc_n[COUNT_BITS-1:0];
      cnt_ext = 32'(cnt);
      pix_dec = pix_e - 1'b1;
      nz_dec  = nz_e - 1'b1;
      pix_sub = pix_e - cnt;
      delta   = acc_n[rvl_pkg::PIX_W:1] ^ {rvl_pkg::PIX_W{acc_n[0]}};   // zigzag
      cur     = prev_e + delta;

      busy_in  = busy_ff;
      word_in  = word_ff;
      idx_in   = idx_ff;
      phase_in = phase_ff;
      acc_in   = acc_ff;
      grp_in   = grp_ff;
      pix_in   = pix_ff;
      nz_in    = nz_ff;
      prev_in  = prev_ff;
      clip_in  = clip_ff;
      emit     = 1'b0;
      ended    = 1'b0;
      word_end = 1'b0;
      new_res  = '0;

      if (step) begin
         phase_in = phase_e;
         acc_in   = acc_e;
         grp_in   = grp_e;
         pix_in   = pix_e;
         nz_in    = nz_e;
         prev_in  = prev_e;
         clip_in  = clip_e;
         if (start && (pix_load == '0)) begin
            word_end = 1'b1;               // empty image: drop the word
         end else begin
            if (nib[3]) begin
               acc_in = acc_n;
               grp_in = grp_n;
            end else begin
               acc_in = '0;
               grp_in = '0;
               case (phase_e)
                  PH_DELTA: begin
                     prev_in              = cur;
                     nz_in                = nz_dec;
                     pix_in               = pix_dec;
                     emit                 = 1'b1;
                     new_res.pixel_value  = cur;
                     new_res.repeat_count = rvl_pkg::REP_W'(1);
                     new_res.image_done   = (pix_dec == '0);
                     new_res.run_overflow = clip_e;
                     if (nz_dec == '0) begin
                        if (pix_dec == '0) begin
                           ended = 1'b1;
                        end else begin
                           phase_in = PH_ZERO;
                        end
                     end
                  end
                  PH_NONZERO: begin
                     clip_in = v_gt;
                     nz_in   = cnt;
                     if (cnt == '0) begin
                        if (pix_e == '0) begin
                           ended = 1'b1;
                        end else begin
                           phase_in = PH_ZERO;
                        end
                     end else begin
                        phase_in = PH_DELTA;
                     end
                  end
                  default: begin
                     pix_in               = pix_sub;
                     emit                 = (cnt != '0);
                     new_res.pixel_value  = '0;
                     new_res.repeat_count = cnt_ext[rvl_pkg::REP_W-1:0];
                     new_res.image_done   = (pix_sub == '0);
                     new_res.run_overflow = v_gt;
                     phase_in             = PH_NONZERO;
                  end
               endcase
            end
            if (ended) begin
               phase_in = PH_ZERO;
               acc_in   = '0;
               grp_in   = '0;
               pix_in   = '0;
               nz_in    = '0;
               clip_in  = 1'b0;
               word_end = 1'b1;
            end
            if (idx_ff == '0) begin
               word_end = 1'b1;
            end
         end
      end

      // one result is held back until we know whether it ends its word
      out_push      = pend_valid_ff && !out_full &&
                      (pend_fin_ff || (step && (emit || word_end)));
      out_data      = pend_ff;
      out_data.last = pend_fin_ff || !emit;

      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      pend_fin_in   = pend_fin_ff;
      if (emit) begin
         pend_in       = new_res;
         pend_valid_in = 1'b1;
         pend_fin_in   = word_end;
      end else if (out_push) begin
         pend_valid_in = 1'b0;
         pend_fin_in   = 1'b0;
      end

      load     = word_valid && (!busy_ff || (step && word_end));
      word_pop = load;
      if (load) begin
         word_in = word_data;
         idx_in  = IDX_FIRST;
         busy_in = 1'b1;
      end else if (step) begin
         if (word_end) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      idx_ff  <= idx_in;
      pend_ff <= pend_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         phase_ff      <= PH_ZERO;
         acc_ff        <= '0;
         grp_ff        <= '0;
         pix_ff        <= '0;
         nz_ff         <= '0;
         prev_ff       <= '0;
         clip_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         pend_fin_ff   <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         phase_ff      <= phase_in;
         acc_ff        <= acc_in;
         grp_ff        <= grp_in;
         pix_ff        <= pix_in;
         nz_ff         <= nz_in;
         prev_ff       <= prev_in;
         clip_ff       <= clip_in;
         pend_valid_ff <= pend_valid_in;
         pend_fin_ff   <= pend_fin_in;
      end
   end

   // a pending nonzero run exists exactly while emitting deltas
   a_nz_phase: assert property (@(posedge clock) disable iff (reset)
      (nz_ff != '0) |-> (phase_ff == PH_DELTA))
      else $error("nonzero run pending outside delta phase");

   a_delta_run: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DELTA) |-> ((nz_ff != '0) && (nz_ff <= pix_ff)))
      else $error("delta run empty or longer than pixels left");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result pushed into full queue");

   a_fin_valid: assert property (@(posedge clock) disable iff (reset)
      pend_fin_ff |-> pend_valid_ff)
      else $error("word-final flag without held result");

   a_fin_drains: assert property (@(posedge clock) disable iff (reset)
      (pend_fin_ff && !out_full) |=> !(pend_fin_ff && $stable(pend_ff) && !emit &&
                                       $past(pend_fin_ff) && !$past(emit)))
      else $error("word-final result not released");

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ---------------------------------------------------------------------------
// RVL depth decoder testbench
// Feeds compressed words through the push/full queue interface, predicts the
// zero-run and pixel results with an in-bench decoder and compares every
// popped result field by field. A directed table runs first, then random
// image streams under several image sizes and idle patterns.
// ---------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES   = 300;   // receiver hold-off that fills the block
   localparam int SETTLE_CYCLES = 40;    // two queued words plus one in the nibble unit
   localparam int FROM_MODEL    = -1;    // row result comes from the predictor
   localparam int MAX_SHOWN     = 10;    // mismatches printed in full
   localparam int NOISE_PCT     = 10;    // raw random words among the stream words

   // decoder phase: what the next finished value means
   typedef enum logic [1:0] {
      DEC_ZERO_RUN,
      DEC_NZ_COUNT,
      DEC_DELTA,
      DEC_SPARE
   } dec_phase_type;

   typedef enum {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type        kind;
      logic [31:0]         data;      // code word, or image size for a CSR row
      int                  n_typed;   // FROM_MODEL, or number of typed results (0 or 1)
      rvl_pkg::result_type typed;
   } dir_row_type;

   // -----------------------------------------------------------------------
   // DUT signals; every input has a known value from time zero
   // -----------------------------------------------------------------------
   logic                        clock         = 1'b0;
   logic                        reset         = 1'b1;
   logic                        req_push      = 1'b0;
   logic                        req_full;
   logic [rvl_pkg::WORD_W-1:0]  req_code_word = '0;
   logic                        rsp_empty;
   logic                        rsp_pop       = 1'b0;
   logic [rvl_pkg::PIX_W-1:0]   rsp_pixel_value;
   logic [rvl_pkg::REP_W-1:0]   rsp_repeat_count;
   logic                        rsp_image_done;
   logic                        rsp_run_overflow;
   logic                        rsp_last;
   logic                        csr_wr_en     = 1'b0;
   logic [rvl_pkg::CFG_W-1:0]   csr_wr_data   = '0;

   rvl_depth_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_code_word    (req_code_word),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_image_done   (rsp_image_done),
      .rsp_run_overflow (rsp_run_overflow),
      .rsp_last         (rsp_last),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // -----------------------------------------------------------------------
   // Decoder shadow state, kept at the block's widths
   // -----------------------------------------------------------------------
   logic [rvl_pkg::CFG_W-1:0]          img_size   = rvl_pkg::CFG_RESET;
   dec_phase_type                      dec_phase  = DEC_ZERO_RUN;
   logic [31:0]                        dec_acc    = '0;   // value under assembly
   logic [3:0]                         dec_grp    = '0;   // 3-bit groups taken so far
   logic [rvl_pkg::COUNT_BITS_DEF-1:0] pix_left   = '0;   // pixels left in the image
   logic [rvl_pkg::COUNT_BITS_DEF-1:0] nz_left    = '0;   // deltas left in the run
   logic [rvl_pkg::PIX_W-1:0]          prev_pix   = '0;
   logic                               nz_clipped = 1'b0; // current nonzero run was cut

   rvl_pkg::result_type word_px[$];       // results of the word just decoded
   rvl_pkg::result_type expected_px[$];   // results still owed by the block

   // stream builder: nibbles of well-formed images, most significant first
   logic [3:0]                         enc_nibs[$];
   logic [rvl_pkg::COUNT_BITS_DEF-1:0] enc_left = '0;

   dir_row_type dir_tab[$];

   // pacing and bookkeeping
   int send_idle_pct = 9;
   int recv_idle_pct = 64;
   bit rsp_hold_ask  = 1'b0;
   int hold_left     = 0;
   int px_errors     = 0;
   int px_seen       = 0;
   int words_sent    = 0;
   int images_done   = 0;
   int clipped_px    = 0;
   int full_stalls   = 0;
   int csr_writes    = 0;

   // -----------------------------------------------------------------------
   // Predictor: decode one accepted word into word_px
   // -----------------------------------------------------------------------
   function automatic void decode_word(input logic [31:0] w);
      rvl_pkg::result_type                held;
      logic                               have_held;
      logic [3:0]                         nib;
      logic [31:0]                        v;
      logic [31:0]                        d;
      logic [rvl_pkg::PIX_W-1:0]          cur;
      logic [rvl_pkg::COUNT_BITS_DEF-1:0] cnt;
      logic                               ovf;
      logic                               ended;
      int                                 i;
      word_px.delete();
      have_held = 1'b0;
      held      = '0;
      // idle: this word opens a new image
      if (dec_phase != DEC_NZ_COUNT && dec_phase != DEC_DELTA && pix_left == 0) begin
         dec_phase  = DEC_ZERO_RUN;
         dec_acc    = '0;
         dec_grp    = '0;
         nz_left    = '0;
         nz_clipped = 1'b0;
         prev_pix   = '0;
         pix_left   = img_size;
         if (pix_left == 0)
            return;   // empty image: word dropped
      end
      for (i = 7; i >= 0; i--) begin
         nib   = w[4*i +: 4];
         ended = 1'b0;
         // groups past the eleventh add nothing; index sticks at 15
         if (dec_grp < 11)
            dec_acc |= {29'd0, nib[2:0]} << (3 * dec_grp);
         if (dec_grp < 15)
            dec_grp++;
         if (!nib[3]) begin
            v       = dec_acc;
            dec_acc = '0;
            dec_grp = '0;
            case (dec_phase)
               DEC_DELTA: begin
                  d   = (v >> 1) ^ {32{v[0]}};   // zigzag back to signed
                  cur = prev_pix + d[rvl_pkg::PIX_W-1:0];
                  prev_pix = cur;
                  nz_left--;
                  pix_left--;
                  if (have_held)
                     word_px = {word_px, held};
                  held      = '{cur, 24'd1, (pix_left == 0), nz_clipped, 1'b0};
                  have_held = 1'b1;
                  if (nz_left == 0) begin
                     if (pix_left == 0)
                        ended = 1'b1;
                     else
                        dec_phase = DEC_ZERO_RUN;
                  end
               end
               DEC_NZ_COUNT: begin
                  // a count past the end of the image is cut and flagged on its deltas
                  nz_clipped = (v > {8'd0, pix_left});
                  cnt        = nz_clipped ? pix_left : v[rvl_pkg::COUNT_BITS_DEF-1:0];
                  nz_left    = cnt;
                  if (cnt == 0) begin
                     if (pix_left == 0)
                        ended = 1'b1;
                     else
                        dec_phase = DEC_ZERO_RUN;
                  end else begin
                     dec_phase = DEC_DELTA;
                  end
               end
               default: begin
                  ovf      = (v > {8'd0, pix_left});
                  cnt      = ovf ? pix_left : v[rvl_pkg::COUNT_BITS_DEF-1:0];
                  pix_left -= cnt;
                  if (cnt != 0) begin
                     if (have_held)
                        word_px = {word_px, held};
                     held      = '{16'd0, cnt, (pix_left == 0), ovf, 1'b0};
                     have_held = 1'b1;
                  end
                  dec_phase = DEC_NZ_COUNT;
               end
            endcase
            if (ended) begin
               // image over: rest of the word is dropped
               dec_phase  = DEC_ZERO_RUN;
               dec_acc    = '0;
               dec_grp    = '0;
               pix_left   = '0;
               nz_left    = '0;
               nz_clipped = 1'b0;
               break;
            end
         end
      end
      if (have_held) begin
         held.last = 1'b1;
         word_px   = {word_px, held};
      end
   endfunction

   // -----------------------------------------------------------------------
   // Stream builder
   // -----------------------------------------------------------------------
   function automatic void put_value(input logic [31:0] v);
      logic [3:0] nib;
      do begin
         nib      = {1'b0, v[2:0]};
         v        = v >> 3;
         nib[3]   = (v != 0);
         enc_nibs = {enc_nibs, nib};
      end while (v != 0);
   endfunction

   // one zero run, one nonzero count and its deltas; pads the word at image end
   function automatic void put_segment();
      longint unsigned left;
      longint unsigned run;
      longint unsigned nz;
      int              roll;
      left = enc_left;
      run  = ($urandom_range(99) < 25) ? 0 : $urandom_range(4, 1);
      if ($urandom_range(99) < 5)
         run = left + $urandom_range(3, 1);
      put_value(32'(run));
      left -= (run > left) ? left : run;
      nz = ($urandom_range(99) < 10) ? 0 : $urandom_range(6, 1);
      if (left <= 16 && $urandom_range(99) < 5)
         nz = left + $urandom_range(3, 1);
      put_value(32'(nz));
      if (nz > left)
         nz = left;
      repeat (nz) begin
         roll = $urandom_range(99);
         if (roll < 70)
            put_value($urandom_range(15));
         else if (roll < 90)
            put_value($urandom_range(65535));
         else
            put_value($urandom());   // up to eleven nibbles
      end
      left    -= nz;
      enc_left = left[rvl_pkg::COUNT_BITS_DEF-1:0];
      if (left == 0)
         while (enc_nibs.size() % 8 != 0)
            enc_nibs = {enc_nibs, 4'($urandom_range(15))};
   endfunction

   function automatic logic [31:0] next_stream_word();
      logic [31:0] w;
      // resync with the decoder whenever it has gone idle
      if (dec_phase != DEC_NZ_COUNT && dec_phase != DEC_DELTA && pix_left == 0) begin
         enc_nibs.delete();
         enc_left = img_size;
      end
      while (enc_nibs.size() < 8) begin
         if (enc_left == 0)
            enc_nibs = {enc_nibs, 4'($urandom_range(15))};
         else
            put_segment();
      end
      w = '0;
      repeat (8)
         w = {w[27:0], enc_nibs.pop_front()};
      return w;
   endfunction

   // -----------------------------------------------------------------------
   // Directed table helpers
   // -----------------------------------------------------------------------
   function automatic rvl_pkg::result_type one_px(input logic [15:0] pix,
                                                  input logic [23:0] rep,
                                                  input logic done, input logic ovf);
      return '{pix, rep, done, ovf, 1'b1};
   endfunction

   function automatic void add_word(input logic [31:0] w, input int n_typed,
                                    input rvl_pkg::result_type r);
      dir_row_type row;
      row.kind    = ROW_WORD;
      row.data    = w;
      row.n_typed = n_typed;
      row.typed   = r;
      dir_tab     = {dir_tab, row};
   endfunction

   function automatic void add_csr(input logic [rvl_pkg::CFG_W-1:0] v);
      dir_row_type row;
      row.kind    = ROW_CSR;
      row.data    = {8'd0, v};
      row.n_typed = 0;
      row.typed   = '0;
      dir_tab     = {dir_tab, row};
   endfunction

   // -----------------------------------------------------------------------
   // Sender side
   // -----------------------------------------------------------------------
   task automatic wait_results_out();
      while (expected_px.size() != 0)
         @(posedge clock);
   endtask

   // one request; push stays high when the next word follows without a gap
   task automatic send_word(input logic [31:0] w, input int n_typed,
                            input rvl_pkg::result_type typed);
      if ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(99) < send_idle_pct);
      end
      req_push      <= 1'b1;
      req_code_word <= w;
      do begin
         @(posedge clock);
         if (req_full)
            full_stalls++;
      end while (req_full);
      decode_word(w);
      words_sent++;
      if (n_typed == FROM_MODEL) begin
         expected_px = {expected_px, word_px};
      end else if (n_typed > 0) begin
         expected_px = {expected_px, typed};
      end
   endtask

   // size register is only touched with the block drained
   task automatic write_size(input logic [rvl_pkg::CFG_W-1:0] v);
      req_push <= 1'b0;
      wait_results_out();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      img_size   = v;
      csr_writes++;
   endtask

   task automatic run_words(input int count);
      logic [31:0] w;
      repeat (count) begin
         if ($urandom_range(99) < NOISE_PCT)
            w = $urandom();
         else
            w = next_stream_word();
         send_word(w, FROM_MODEL, '0);
      end
   endtask

   // -----------------------------------------------------------------------
   // Receiver side: check on pop, then choose next pop
   // -----------------------------------------------------------------------
   task automatic check_px();
      rvl_pkg::result_type got;
      rvl_pkg::result_type want;
      got = '{rsp_pixel_value, rsp_repeat_count, rsp_image_done, rsp_run_overflow, rsp_last};
      px_seen++;
      if (expected_px.size() == 0) begin
         if (px_errors < MAX_SHOWN)
            $display("ERROR: unexpected result pix=%h rep=%0d done=%b ovf=%b last=%b",
                     got.pixel_value, got.repeat_count, got.image_done,
                     got.run_overflow, got.last);
         px_errors++;
      end else begin
         want = expected_px.pop_front();
         if (got.pixel_value  !== want.pixel_value  ||
             got.repeat_count !== want.repeat_count ||
             got.image_done   !== want.image_done   ||
             got.run_overflow !== want.run_overflow ||
             got.last         !== want.last) begin
            if (px_errors < MAX_SHOWN) begin
               $display("ERROR: result %0d expected pix=%h rep=%0d done=%b ovf=%b last=%b",
                        px_seen, want.pixel_value, want.repeat_count, want.image_done,
                        want.run_overflow, want.last);
               $display("       got               pix=%h rep=%0d done=%b ovf=%b last=%b",
                        got.pixel_value, got.repeat_count, got.image_done,
                        got.run_overflow, got.last);
            end
            px_errors++;
         end
         if (want.image_done)
            images_done++;
         if (want.run_overflow)
            clipped_px++;
      end
   endtask

   // hold-off is counted here so the sender keeps pushing meanwhile
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty)
         check_px();
      if (rsp_hold_ask) begin
         hold_left    = HOLD_CYCLES;
         rsp_hold_ask = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= !reset && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // -----------------------------------------------------------------------
   // Stimulus
   // -----------------------------------------------------------------------
   initial begin
      int r;

      // --- directed table ---
      // reset size 307200: a short zero run, then one clipped to what is left
      add_word(32'h3000_0000, 1, one_px(16'h0000, 24'd3, 1'b0, 1'b0));
      add_word(32'hFFFF_FFF7, 1, one_px(16'h0000, 24'd307197, 1'b1, 1'b1));
      add_word(32'h0000_0000, 0, '0);          // trailing count closes the image
      add_csr(24'd4);
      add_word(32'h1223_10FF, FROM_MODEL, '0); // +1, then -2 wrapping to 0xFFFF
      add_word(32'h0722_2200, FROM_MODEL, '0); // nonzero run cut to the image
      // zero run cut, then a count with nothing left is dropped quietly
      add_word(32'h5300_0000, 1, one_px(16'h0000, 24'd4, 1'b1, 1'b1));
      // largest zigzag codes, each eleven nibbles across word edges
      add_word(32'h01FF_FFFF, FROM_MODEL, '0);
      add_word(32'hFFFF_301E, FROM_MODEL, '0);
      add_word(32'hFFFF_FFFF, FROM_MODEL, '0);
      add_word(32'hF300_0000, FROM_MODEL, '0);
      add_word(32'h2000_0000, FROM_MODEL, '0);
      add_csr(24'd0);
      add_word(32'h1234_5678, 0, '0);          // empty image drops the word
      add_csr(24'hFF_FFFF);
      add_word(32'hFFFF_FFF7, 1, one_px(16'h0000, 24'hFF_FFFF, 1'b1, 1'b0));
      add_word(32'h0000_0000, 0, '0);
      // sixteen nibbles: groups past the eleventh fall away, value saturates
      add_word(32'hFFFF_FFFF, 0, '0);
      add_word(32'hFFFF_FFF1, 1, one_px(16'h0000, 24'hFF_FFFF, 1'b1, 1'b1));
      add_word(32'h0000_0000, 0, '0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (r = 0; r < dir_tab.size(); r++) begin
         if (dir_tab[r].kind == ROW_CSR)
            write_size(dir_tab[r].data[rvl_pkg::CFG_W-1:0]);
         else
            send_word(dir_tab[r].data, dir_tab[r].n_typed, dir_tab[r].typed);
      end

      // --- random streams, sender mostly busy, receiver mostly idle ---
      write_size(24'd9);
      run_words(110);
      write_size(24'd1);
      run_words(50);

      // --- roles swapped ---
      send_idle_pct = 64;
      recv_idle_pct = 9;
      write_size(24'd37);
      run_words(60);
      // receiver stops for a while; sender keeps pushing until full
      send_idle_pct = 0;
      rsp_hold_ask  = 1'b1;
      run_words(30);
      send_idle_pct = 64;
      // sender waits for the block to drain completely
      req_push <= 1'b0;
      wait_results_out();
      @(posedge clock);
      run_words(50);

      // --- no idling, large images ---
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_size(24'hFF_FFFF);
      run_words(50);
      write_size(rvl_pkg::CFG_RESET);
      run_words(50);

      req_push <= 1'b0;
      wait_results_out();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d words, %0d results, %0d image ends, %0d clipped results.",
               words_sent, px_seen, images_done, clipped_px);
      $display("Sizes 0 to 16777215 over %0d size writes; %0d cycles with input full.",
               csr_writes, full_stalls);
      if (px_errors == 0)
         $display("rvl_depth_decoder verification clean");
      else
         $display("rvl_depth_decoder verification failed");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("rvl_depth_decoder verification failed");
      $finish;
   end

endmodule
